[rtl/pts_pkg.sv]
// ---------------------------------------------------------------------------
// pts_pkg
// shared constants, codes and control types of the task scheduler table
// ---------------------------------------------------------------------------
package pts_pkg;

    localparam int NUM_SLOTS  = 8;
    localparam int RESULT_CAP = 8;
    localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W      = (RESULT_CAP > 1) ? $clog2(RESULT_CAP) : 1;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 16;

    typedef enum logic [1:0] {
        MODE_ADD  = 2'd0,
        MODE_DEL  = 2'd1,
        MODE_TICK = 2'd2,
        MODE_DISP = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_DONE    = 3'd0,
        ST_FULL    = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_RANGE   = 3'd3,
        ST_RUN     = 3'd4,
        ST_NOTHING = 3'd5
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic load;        // capture the input word and restart the walk
        logic step;        // process the slot under the walk pointer
        logic final_push;  // write the closing result word
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_del;      // incoming word is a delete, no walk needed
        logic walk_done;   // this step is the last of the walk
        logic out_free;    // output register can take a word this cycle
    } t_sts;

endpackage

[rtl/pts_ctrl.sv]
// ---------------------------------------------------------------------------
// pts_ctrl
// sequencer: accepts a word, runs the slot walk (skipped for delete), then the closing result
// ---------------------------------------------------------------------------
module pts_ctrl
    import pts_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_ready, n_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid && r_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.in_del ? S_FIN : S_WALK;
                end
            end
            S_WALK: begin
                if (i_sts.out_free) begin
                    o_cmd.step = 1'b1;
                    if (i_sts.walk_done) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.final_push = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_ready = (n_state == S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
        end
    end

    assign o_s_tready = r_ready;

endmodule

[rtl/pts_dp.sv]
// ---------------------------------------------------------------------------
// pts_dp
// slot table, walk pointer, held dispatch result and output register
// ---------------------------------------------------------------------------
module pts_dp
    import pts_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                   i_m_tready,
    output logic                   o_m_tvalid,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    output logic                   o_m_tlast,
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts
);

    // slot table, valid marks reset, the rest is written before any read
    logic [NUM_SLOTS-1:0] r_valid;
    logic [7:0]           r_task   [NUM_SLOTS];
    logic [15:0]          r_count  [NUM_SLOTS];
    logic [15:0]          r_period [NUM_SLOTS];
    logic [7:0]           r_pend   [NUM_SLOTS];

    // captured input word
    t_mode       r_mode;
    logic [7:0]  r_id;
    logic [15:0] r_delay;
    logic [15:0] r_rper;
    logic [7:0]  r_target;

    // walk state
    logic [SLOT_W-1:0] r_ptr;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_found;
    logic [2:0]        r_fidx;
    logic              r_hold_v;
    logic [2:0]        r_hold_idx;
    logic [7:0]        r_hold_id;

    // output register
    logic        r_o_valid;
    t_status     r_o_status;
    logic [2:0]  r_o_idx;
    logic [7:0]  r_o_id;
    logic        r_o_last;

    logic              s_valid_p;
    logic [7:0]        s_pend_p;
    logic [15:0]       s_count_p;
    logic [15:0]       s_period_p;
    logic [7:0]        s_task_p;
    logic [2:0]        s_idx_p;
    logic              s_add_hit;
    logic              s_disp_hit;
    logic              s_push;
    t_status           s_push_status;
    logic [2:0]        s_push_idx;
    logic [7:0]        s_push_id;
    logic              s_push_last;
    logic              s_tgt_ok;
    logic [SLOT_W-1:0] s_tgt;

    assign s_valid_p  = r_valid[r_ptr];
    assign s_pend_p   = r_pend[r_ptr];
    assign s_count_p  = r_count[r_ptr];
    assign s_period_p = r_period[r_ptr];
    assign s_task_p   = r_task[r_ptr];
    assign s_idx_p    = 3'(r_ptr);

    assign s_add_hit  = (r_mode == MODE_ADD) && !s_valid_p;
    assign s_disp_hit = (r_mode == MODE_DISP) && s_valid_p && (s_pend_p != 8'd0);

    assign s_tgt_ok = (r_target < 8'(NUM_SLOTS));
    assign s_tgt    = SLOT_W'(r_target);

    assign o_sts.in_del    = (t_mode'(i_s_tdata[1:0]) == MODE_DEL);
    assign o_sts.out_free  = !r_o_valid || i_m_tready;
    assign o_sts.walk_done = (r_ptr == SLOT_W'(NUM_SLOTS - 1)) || s_add_hit ||
                             (s_disp_hit && (r_cnt == CNT_W'(RESULT_CAP - 1)));

    // result word selection
    always_comb begin
        s_push        = 1'b0;
        s_push_status = ST_DONE;
        s_push_idx    = 3'd0;
        s_push_id     = 8'd0;
        s_push_last   = 1'b1;
        if (i_cmd.step && s_disp_hit && r_hold_v) begin
            // an earlier run is known not to be the final one
            s_push        = 1'b1;
            s_push_status = ST_RUN;
            s_push_idx    = r_hold_idx;
            s_push_id     = r_hold_id;
            s_push_last   = 1'b0;
        end else if (i_cmd.final_push) begin
            s_push = 1'b1;
            case (r_mode)
                MODE_ADD: begin
                    s_push_status = r_found ? ST_DONE : ST_FULL;
                    s_push_idx    = r_found ? r_fidx : 3'd0;
                end
                MODE_DEL: begin
                    s_push_idx = r_target[2:0];
                    if (!s_tgt_ok) begin
                        s_push_status = ST_RANGE;
                    end else if (!r_valid[s_tgt]) begin
                        s_push_status = ST_EMPTY;
                    end else begin
                        s_push_status = ST_DONE;
                    end
                end
                MODE_TICK: s_push_status = ST_DONE;
                MODE_DISP: begin
                    if (r_hold_v) begin
                        s_push_status = ST_RUN;
                        s_push_idx    = r_hold_idx;
                        s_push_id     = r_hold_id;
                    end else begin
                        s_push_status = ST_NOTHING;
                    end
                end
                default: s_push_status = ST_DONE;
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_o_valid <= 1'b0;
            r_hold_v  <= 1'b0;
            r_found   <= 1'b0;
            r_ptr     <= '0;
            r_cnt     <= '0;
        end else begin
            if (s_push) begin
                r_o_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end

            if (i_cmd.load) begin
                r_ptr    <= '0;
                r_cnt    <= '0;
                r_found  <= 1'b0;
                r_hold_v <= 1'b0;
            end else if (i_cmd.step) begin
                r_ptr <= r_ptr + 1'b1;
                if (s_add_hit) begin
                    r_valid[r_ptr] <= 1'b1;
                    r_found        <= 1'b1;
                end
                if (s_disp_hit) begin
                    r_hold_v <= 1'b1;
                    r_cnt    <= r_cnt + 1'b1;
                    // one-shot task leaves the table once it has run
                    if (s_period_p == 16'd0) begin
                        r_valid[r_ptr] <= 1'b0;
                    end
                end
            end else if (i_cmd.final_push) begin
                if (r_mode == MODE_DEL && s_tgt_ok) begin
                    r_valid[s_tgt] <= 1'b0;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode   <= t_mode'(i_s_tdata[1:0]);
            r_id     <= i_s_tdata[9:2];
            r_delay  <= i_s_tdata[25:10];
            r_rper   <= i_s_tdata[41:26];
            r_target <= i_s_tdata[49:42];
        end
        if (i_cmd.step) begin
            if (s_add_hit) begin
                r_task[r_ptr]   <= r_id;
                r_count[r_ptr]  <= r_delay;
                r_period[r_ptr] <= r_rper;
                r_pend[r_ptr]   <= 8'd0;
                r_fidx          <= s_idx_p;
            end
            if (r_mode == MODE_TICK && s_valid_p) begin
                if (s_count_p == 16'd0) begin
                    if (s_pend_p != 8'hFF) begin
                        r_pend[r_ptr] <= s_pend_p + 8'd1;
                    end
                    if (s_period_p != 16'd0) begin
                        r_count[r_ptr] <= s_period_p;
                    end
                end else begin
                    r_count[r_ptr] <= s_count_p - 16'd1;
                end
            end
            if (s_disp_hit) begin
                r_pend[r_ptr] <= s_pend_p - 8'd1;
                r_hold_idx    <= s_idx_p;
                r_hold_id     <= s_task_p;
            end
        end
        if (s_push) begin
            r_o_status <= s_push_status;
            r_o_idx    <= s_push_idx;
            r_o_id     <= s_push_id;
            r_o_last   <= s_push_last;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {2'b00, r_o_id, r_o_idx, r_o_status};
    assign o_m_tlast  = r_o_last;

endmodule

[rtl/periodic_task_scheduler_table.sv]
// ---------------------------------------------------------------------------
// periodic_task_scheduler_table
// time-triggered task table: add, delete, tick and dispatch over slot table
//
//   channel  dir  handshake                    word contents
//   s        in   i_s_tvalid / o_s_tready      mode, task_id, first_delay,
//                                              repeat_period, slot
//   m        out  o_m_tvalid / i_m_tready      status, slot_index, run_task_id,
//                                              last on o_m_tlast
//
// add, tick and dispatch walk the table one slot per cycle through a single
// slot read port, over up to NUM_SLOTS slots, then write a closing result;
// delete skips the walk and writes only its closing result. add stops at the first free slot.
// a new word is taken once the previous one has written its closing result,
// even while that result still waits in the output register.
// the walk pauses while the output register is full and not taken.
// synchronous reset clears the valid marks and the handshake state.
// ---------------------------------------------------------------------------
module periodic_task_scheduler_table
    import pts_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // mode[1:0], task_id[9:2], first_delay[25:10], repeat_period[41:26],
    // slot[49:42], zero fill
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // status[2:0], slot_index[5:3], run_task_id[13:6], zero fill
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    output logic                   o_m_tlast
);

    t_cmd s_cmd;
    t_sts s_sts;

    pts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (s_sts),
        .o_cmd      (s_cmd)
    );

    pts_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .i_cmd      (s_cmd),
        .o_sts      (s_sts)
    );

    // one word in flight: accept is followed by a busy cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input accepted while previous word still in progress");

    // only dispatch runs produce words that are not the final one
    a_nonlast_is_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tlast) |-> (o_m_tdata[2:0] == ST_RUN))
        else $error("non-final result word is not a run word");

    // the walk and closing step never run alongside a capture
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({s_cmd.load, s_cmd.step, s_cmd.final_push}))
        else $error("controller issued overlapping commands");

endmodule

[bench/pts_tb_pkg.sv]
// ---------------------------------------------------------------------------
// pts_tb_pkg
// slot table predictor and result checker for the task scheduler table bench
// ---------------------------------------------------------------------------
package pts_tb_pkg;

    import pts_pkg::*;

    typedef struct {
        t_status    status;
        logic [2:0] slot_index;
        logic [7:0] run_id;
        logic       last;
    } t_reply;

    class sched_table_book;

        logic        live     [NUM_SLOTS];
        logic [7:0]  owner    [NUM_SLOTS];
        logic [15:0] countdown[NUM_SLOTS];
        logic [15:0] period   [NUM_SLOTS];
        logic [7:0]  pending  [NUM_SLOTS];

        t_reply      awaited[$];

        int          errors;
        int          words_in;
        int          replies_seen;
        int          runs_seen;
        int          full_seen;
        int          mode_count[4];

        function new();
            for (int s = 0; s < NUM_SLOTS; s++)
                clear_entry(s);
            errors       = 0;
            words_in     = 0;
            replies_seen = 0;
            runs_seen    = 0;
            full_seen    = 0;
            for (int m = 0; m < 4; m++)
                mode_count[m] = 0;
        endfunction

        function void clear_entry(int s);
            live[s]      = 1'b0;
            owner[s]     = 8'd0;
            countdown[s] = 16'd0;
            period[s]    = 16'd0;
            pending[s]   = 8'd0;
        endfunction

        function void await_reply(t_status st, int idx, logic [7:0] id, logic last);
            t_reply r;
            r.status     = st;
            r.slot_index = idx[2:0];
            r.run_id     = id;
            r.last       = last;
            awaited.push_back(r);
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction

        // applies one accepted command word to the table and queues its results
        function void apply_command(t_mode mode, logic [7:0] id, logic [15:0] dly,
                                    logic [15:0] per, logic [7:0] sl);
            bit     placed;
            int     runs;
            t_reply closing;
            words_in++;
            mode_count[mode]++;
            case (mode)
                MODE_ADD: begin
                    placed = 1'b0;
                    for (int s = 0; s < NUM_SLOTS; s++) begin
                        if (!placed && !live[s]) begin
                            live[s]      = 1'b1;
                            owner[s]     = id;
                            countdown[s] = dly;
                            period[s]    = per;
                            pending[s]   = 8'd0;
                            await_reply(ST_DONE, s, 8'd0, 1'b1);
                            placed = 1'b1;
                        end
                    end
                    if (!placed)
                        await_reply(ST_FULL, 0, 8'd0, 1'b1);
                end
                MODE_DEL: begin
                    if (sl >= NUM_SLOTS) begin
                        await_reply(ST_RANGE, sl, 8'd0, 1'b1);
                    end else begin
                        await_reply(live[sl] ? ST_DONE : ST_EMPTY, sl, 8'd0, 1'b1);
                        clear_entry(sl);
                    end
                end
                MODE_TICK: begin
                    for (int s = 0; s < NUM_SLOTS; s++) begin
                        if (live[s]) begin
                            if (countdown[s] == 16'd0) begin
                                if (pending[s] != 8'hFF)
                                    pending[s] = pending[s] + 8'd1;
                                if (period[s] != 16'd0)
                                    countdown[s] = period[s];
                            end else begin
                                countdown[s] = countdown[s] - 16'd1;
                            end
                        end
                    end
                    await_reply(ST_DONE, 0, 8'd0, 1'b1);
                end
                default: begin
                    runs = 0;
                    for (int s = 0; s < NUM_SLOTS && runs < RESULT_CAP; s++) begin
                        if (live[s] && pending[s] != 8'd0) begin
                            await_reply(ST_RUN, s, owner[s], 1'b0);
                            runs++;
                            pending[s] = pending[s] - 8'd1;
                            // one-shot tasks leave the table, leftover runs dropped
                            if (period[s] == 16'd0)
                                clear_entry(s);
                        end
                    end
                    if (runs == 0) begin
                        await_reply(ST_NOTHING, 0, 8'd0, 1'b1);
                    end else begin
                        closing      = awaited.pop_back();
                        closing.last = 1'b1;
                        awaited.push_back(closing);
                    end
                end
            endcase
        endfunction

        function void report(string what, int want, int got, time stamp);
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", stamp, what, want, got);
        endfunction

        function void check_reply(logic [OUT_TDATA_W-1:0] word, logic tlast, time stamp);
            t_reply want;
            replies_seen++;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t ns: result word with none awaited, expected none, actual %h last %b",
                         stamp, word, tlast);
                return;
            end
            want = awaited.pop_front();
            if (word[2:0] === ST_RUN)
                runs_seen++;
            if (word[2:0] === ST_FULL)
                full_seen++;
            if (word[2:0] !== want.status)
                report("status", want.status, word[2:0], stamp);
            if (word[5:3] !== want.slot_index)
                report("slot_index", want.slot_index, word[5:3], stamp);
            if (word[13:6] !== want.run_id)
                report("run_task_id", want.run_id, word[13:6], stamp);
            if (word[OUT_TDATA_W-1:14] !== '0)
                report("zero fill", 0, word[OUT_TDATA_W-1:14], stamp);
            if (tlast !== want.last)
                report("tlast", want.last, tlast, stamp);
        endfunction

    endclass

endpackage

[bench/tb_periodic_task_scheduler_table.sv]
// ---------------------------------------------------------------------------
// tb_periodic_task_scheduler_table
// self-checking bench: directed table cases, a pending build-up run
// and random command traffic with random stalls on both stream sides
// ---------------------------------------------------------------------------
module tb_periodic_task_scheduler_table;

    timeunit 1ns;
    timeprecision 1ps;

    import pts_pkg::*;
    import pts_tb_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int RANDOM_WORDS = 212;
    localparam int CALM_WORDS  = 40;

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata  = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tlast;

    bit                     quiet      = 1'b0;
    int                     stall_left = 0;
    int                     idle_cycles = 0;

    sched_table_book        book = new();

    periodic_task_scheduler_table u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            book.check_reply(o_m_tdata, o_m_tlast, $time);
    end

    // receiver: ready drops at random in bursts, and stays high in the quiet phase
    always @(posedge i_clk) begin
        if (quiet) begin
            i_m_tready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (i_m_tready) begin
            if ($urandom_range(0, 5) == 0) begin
                i_m_tready <= 1'b0;
                stall_left <= $urandom_range(0, 9);
            end
        end else begin
            i_m_tready <= 1'b1;
            stall_left <= $urandom_range(0, 20);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t ns: no word moved for %0d cycles", $time, idle_cycles);
            $display("periodic_task_scheduler_table regression: fail");
            $finish;
        end
    end

    task automatic send_word(input t_mode m, input logic [7:0] id, input logic [15:0] dly,
                             input logic [15:0] per, input logic [7:0] sl);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {6'd0, sl, per, dly, id, m};
        do @(posedge i_clk); while (!o_s_tready);
        book.apply_command(m, id, dly, per, sl);
    endtask

    // short delays and periods keep tasks firing; now and then full-range values
    task automatic send_random();
        int          pick;
        t_mode       m;
        logic [15:0] dly;
        logic [15:0] per;
        logic [7:0]  sl;
        pick = $urandom_range(0, 99);
        m    = (pick < 30) ? MODE_ADD : (pick < 45) ? MODE_DEL :
               (pick < 80) ? MODE_TICK : MODE_DISP;
        dly  = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
        per  = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
        sl   = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, NUM_SLOTS - 1));
        send_word(m, 8'($urandom), dly, per, sl);
    endtask

    initial begin
        int k;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table answers
        send_word(MODE_DISP, 8'h3C, 16'h1234, 16'h4321, 8'h00);
        send_word(MODE_DEL,  8'h00, 16'h0000, 16'h0000, 8'd0);
        send_word(MODE_DEL,  8'h00, 16'h0000, 16'h0000, 8'd8);
        send_word(MODE_DEL,  8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF);

        // fill every slot, then one more add
        send_word(MODE_ADD, 8'h00, 16'h0000, 16'h0000, 8'h00);
        send_word(MODE_ADD, 8'hFF, 16'h0000, 16'hFFFF, 8'h00);
        send_word(MODE_ADD, 8'hA5, 16'h0001, 16'h0002, 8'h00);
        for (k = 3; k < NUM_SLOTS; k++)
            send_word(MODE_ADD, 8'(k * 17), 16'h0000, 16'(k - 2), 8'h00);
        send_word(MODE_ADD, 8'h5A, 16'h0001, 16'h0001, 8'h00);

        // one-shot in slot 0 collects three runs, then all slots dispatch at once
        repeat (3) send_word(MODE_TICK, 8'h00, 16'h0000, 16'h0000, 8'h00);
        send_word(MODE_DISP, 8'h00, 16'h0000, 16'h0000, 8'h00);
        send_word(MODE_DISP, 8'h00, 16'h0000, 16'h0000, 8'h00);

        send_word(MODE_DEL, 8'h00, 16'h0000, 16'h0000, 8'd1);
        send_word(MODE_DEL, 8'h00, 16'h0000, 16'h0000, 8'd1);
        send_word(MODE_ADD, 8'h81, 16'hFFFF, 16'h8000, 8'h00);
        send_word(MODE_TICK, 8'h00, 16'h0000, 16'h0000, 8'h00);
        send_word(MODE_DISP, 8'h00, 16'h0000, 16'h0000, 8'h00);

        // pending runs pile up: a one-shot due on every tick and a periodic
        // task due on every other tick
        for (k = 0; k < NUM_SLOTS; k++)
            send_word(MODE_DEL, 8'h00, 16'h0000, 16'h0000, 8'(k));
        send_word(MODE_ADD, 8'h11, 16'h0000, 16'h0000, 8'h00);
        send_word(MODE_ADD, 8'h22, 16'h0000, 16'h0001, 8'h00);
        repeat (12) send_word(MODE_TICK, 8'($urandom), 16'($urandom), 16'($urandom),
                              8'($urandom));
        repeat (3) send_word(MODE_DISP, 8'h00, 16'h0000, 16'h0000, 8'h00);

        for (k = 0; k < RANDOM_WORDS; k++) begin
            if (k == RANDOM_WORDS - CALM_WORDS)
                quiet = 1'b1;
            send_random();
        end
        i_s_tvalid <= 1'b0;

        while (book.outstanding() != 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);

        $display("sent %0d command words: %0d add, %0d delete, %0d tick, %0d dispatch",
                 book.words_in, book.mode_count[MODE_ADD], book.mode_count[MODE_DEL],
                 book.mode_count[MODE_TICK], book.mode_count[MODE_DISP]);
        $display("compared %0d result words, %0d task runs, %0d table-full answers",
                 book.replies_seen, book.runs_seen, book.full_seen);
        if (book.errors == 0)
            $display("periodic_task_scheduler_table regression: pass");
        else
            $display("periodic_task_scheduler_table regression: fail");
        $finish;
    end

endmodule
